@@ hdl/tws_pkg.sv @@
// ---------------------------------------------------------------------------
// tws_pkg
// Shared codes, default sizes and the request/response types of the
// arithmetic unit used by the timer scheduler.
// ---------------------------------------------------------------------------
package tws_pkg;

  localparam int WHEEL_SLOTS_DEF   = 256;
  localparam int HEAP_ENTRIES_DEF  = 32;
  localparam int TIMER_ENTRIES_DEF = 64;

  // input actions
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        lt;
    logic        eq;
  } alu_rsp_t;

endpackage

@@ hdl/tws_alu.sv @@
// ---------------------------------------------------------------------------
// tws_alu
// Shared 64-bit add and compare unit: sum, unsigned less-than and equality.
// ---------------------------------------------------------------------------
module tws_alu (
  input  tws_pkg::alu_req_t req,
  output tws_pkg::alu_rsp_t rsp
);
  import tws_pkg::*;

  always_comb begin
    rsp.sum = req.a + req.b;
    rsp.lt  = (req.a < req.b);
    rsp.eq  = (req.a == req.b);
  end

endmodule

@@ hdl/tws_ctrl.sv @@
// ---------------------------------------------------------------------------
// tws_ctrl
// Sequencer of the timer scheduler: wheel, entry pool, expiry heap, expiry
// stack and output register. The 64-bit time additions and key comparisons go through the shared unit.
// ---------------------------------------------------------------------------
module tws_ctrl #(
  parameter int WHEEL_SLOTS   = tws_pkg::WHEEL_SLOTS_DEF,
  parameter int HEAP_ENTRIES  = tws_pkg::HEAP_ENTRIES_DEF,
  parameter int TIMER_ENTRIES = tws_pkg::TIMER_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_delay_ticks,
  input  logic [31:0]       in_cancel_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [1:0]        out_status,
  output logic [31:0]       out_timer_id,
  output logic              out_last,
  output tws_pkg::alu_req_t alu_req,
  input  tws_pkg::alu_rsp_t alu_rsp
);
  import tws_pkg::*;

  localparam int SW    = $clog2(WHEEL_SLOTS);
  localparam int TW    = $clog2(TIMER_ENTRIES);
  localparam int EW    = $clog2(TIMER_ENTRIES + 1);
  localparam int HW    = $clog2(HEAP_ENTRIES);
  localparam int HCW   = $clog2(HEAP_ENTRIES + 1);
  localparam int CW    = HCW + 1;
  localparam int CNW   = $clog2(TIMER_ENTRIES + 1);
  localparam int SWEEP = (WHEEL_SLOTS > TIMER_ENTRIES) ? WHEEL_SLOTS : TIMER_ENTRIES;
  localparam int MAXN  = (SWEEP > HEAP_ENTRIES) ? SWEEP : HEAP_ENTRIES;
  localparam int IW    = $clog2(MAXN + 1);
  localparam logic [EW-1:0] NIL = EW'(TIMER_ENTRIES);

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_RESP,
    A_CALC, A_CHK, A_WH, A_HLINK, A_SRD, A_SCMP, A_UPRD, A_UPCMP,
    C_START, C_WRD, C_WQ, C_WALK, C_ECMP, C_HRD, C_HQ,
    T_CALC, T_WRD, T_WQ, T_PUSH, T_LNK, T_POP, T_PE, T_PRD, T_PACT,
    T_HROOT, T_HCMP, T_PLAST, T_PLQ, T_SDL, T_SDLQ, T_SDR, T_SDRQ, T_SDDEC,
    T_WALK, T_WACT, T_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] now_r, now_nxt, exp_r, exp_nxt, mk_r, mk_nxt, lk_r, lk_nxt;
  logic [31:0] idc_r, idc_nxt, id_r, id_nxt, d_r, d_nxt, pend_id_r, pend_id_nxt;
  logic [EW-1:0] free_r, free_nxt, e_r, e_nxt, mh_r, mh_nxt, lh_r, lh_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic ph_r, ph_nxt, msel_r, msel_nxt, pend_vld_r, pend_vld_nxt;
  logic [HCW-1:0] hcnt_r, hcnt_nxt;
  logic [CW-1:0] hi_r, hi_nxt, m_r, m_nxt;
  logic [TIMER_ENTRIES-1:0] act_r, act_nxt;
  logic [1:0] kind_r, kind_nxt, st_r, st_nxt;
  logic out_vld_r, out_vld_nxt, out_last_r, out_last_nxt;
  logic [1:0] out_kind_r, out_kind_nxt, out_st_r, out_st_nxt;
  logic [31:0] out_id_r, out_id_nxt;

  // memories
  logic [EW-1:0] wh_mem [WHEEL_SLOTS];
  logic [31:0]   id_mem [TIMER_ENTRIES];
  logic [EW-1:0] lk_mem [TIMER_ENTRIES];
  logic [63:0]   hk_mem [HEAP_ENTRIES];
  logic [EW-1:0] hh_mem [HEAP_ENTRIES];
  logic [EW-1:0] stk_mem [TIMER_ENTRIES];

  logic          wh_we;
  logic [SW-1:0] wh_wa, wh_ra;
  logic [EW-1:0] wh_wd, wh_q;
  logic          id_we;
  logic [TW-1:0] id_wa, ent_ra;
  logic [31:0]   id_q;
  logic          lk_we;
  logic [TW-1:0] lk_wa;
  logic [EW-1:0] lk_wd, lk_q;
  logic          hp_we;
  logic [HW-1:0] hp_wa, hp_ra;
  logic [63:0]   hp_wkey, hk_q;
  logic [EW-1:0] hp_whead, hh_q;
  logic          stk_we;
  logic [TW-1:0] stk_wa, stk_ra;
  logic [EW-1:0] stk_q;

  logic [CW-1:0] lft, rgt, par, hcnt_ext;
  logic          out_free;

  assign lft      = CW'({hi_r, 1'b0}) + CW'(1);
  assign rgt      = lft + CW'(1);
  assign par      = (hi_r - CW'(1)) >> 1;
  assign hcnt_ext = CW'(hcnt_r);
  assign out_free = !out_vld_r || !out_stall;

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_vld_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_st_r;
  assign out_timer_id = out_id_r;
  assign out_last     = out_last_r;

  always_ff @(posedge clk) begin
    if (wh_we) wh_mem[wh_wa] <= wh_wd;
    wh_q <= wh_mem[wh_ra];
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_wa] <= id_r;
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    id_q <= id_mem[ent_ra];
    lk_q <= lk_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      hk_mem[hp_wa] <= hp_wkey;
      hh_mem[hp_wa] <= hp_whead;
    end
    hk_q <= hk_mem[hp_ra];
    hh_q <= hh_mem[hp_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= e_r;
    stk_q <= stk_mem[stk_ra];
  end

  // read addresses
  always_comb begin
    wh_ra  = exp_r[SW-1:0];
    hp_ra  = hi_r[HW-1:0];
    ent_ra = (state_r == A_CHK) ? free_r[TW-1:0] : e_r[TW-1:0];
    stk_ra = TW'(cnt_r - CNW'(1));
    case (state_r)
      C_WRD:   wh_ra = idx_r[SW-1:0];
      T_WRD:   wh_ra = now_r[SW-1:0];
      default: wh_ra = exp_r[SW-1:0];
    endcase
    case (state_r)
      A_UPRD:  hp_ra = par[HW-1:0];
      C_HRD:   hp_ra = idx_r[HW-1:0];
      T_HROOT: hp_ra = '0;
      T_PLAST: hp_ra = hcnt_r[HW-1:0];
      T_SDL:   hp_ra = lft[HW-1:0];
      T_SDR:   hp_ra = rgt[HW-1:0];
      default: hp_ra = hi_r[HW-1:0];
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    exp_nxt      = exp_r;
    mk_nxt       = mk_r;
    lk_nxt       = lk_r;
    idc_nxt      = idc_r;
    id_nxt       = id_r;
    d_nxt        = d_r;
    pend_id_nxt  = pend_id_r;
    pend_vld_nxt = pend_vld_r;
    free_nxt     = free_r;
    e_nxt        = e_r;
    mh_nxt       = mh_r;
    lh_nxt       = lh_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    ph_nxt       = ph_r;
    msel_nxt     = msel_r;
    hcnt_nxt     = hcnt_r;
    hi_nxt       = hi_r;
    m_nxt        = m_r;
    act_nxt      = act_r;
    kind_nxt     = kind_r;
    st_nxt       = st_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_last_nxt = out_last_r;
    out_kind_nxt = out_kind_r;
    out_st_nxt   = out_st_r;
    out_id_nxt   = out_id_r;
    alu_req.a    = now_r;
    alu_req.b    = exp_r;
    wh_we        = 1'b0;
    wh_wa        = exp_r[SW-1:0];
    wh_wd        = NIL;
    id_we        = 1'b0;
    id_wa        = e_r[TW-1:0];
    lk_we        = 1'b0;
    lk_wa        = e_r[TW-1:0];
    lk_wd        = NIL;
    hp_we        = 1'b0;
    hp_wa        = hi_r[HW-1:0];
    hp_wkey      = exp_r;
    hp_whead     = e_r;
    stk_we       = 1'b0;
    stk_wa       = cnt_r[TW-1:0];

    case (state_r)
      S_INIT: begin
        if (idx_r < IW'(WHEEL_SLOTS)) begin
          wh_we = 1'b1;
          wh_wa = idx_r[SW-1:0];
        end
        if (idx_r < IW'(TIMER_ENTRIES)) begin
          lk_we = 1'b1;
          lk_wa = idx_r[TW-1:0];
          lk_wd = EW'(idx_r + IW'(1));
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(SWEEP - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_ADD: begin
              kind_nxt  = KIND_ADD;
              id_nxt    = idc_r;
              idc_nxt   = (idc_r == 32'hFFFF_FFFF) ? 32'd1 : idc_r + 32'd1;
              d_nxt     = (in_delay_ticks == 32'd0) ? 32'd1 : in_delay_ticks;
              state_nxt = A_CALC;
            end
            ACT_CANCEL: begin
              kind_nxt  = KIND_CANCEL;
              id_nxt    = in_cancel_id;
              state_nxt = C_START;
            end
            ACT_TICK: state_nxt = T_CALC;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = kind_r;
          out_st_nxt   = st_r;
          out_id_nxt   = id_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      // ---- add
      A_CALC: begin
        alu_req.a = now_r;
        alu_req.b = {32'd0, d_r};
        exp_nxt   = alu_rsp.sum;
        state_nxt = A_CHK;
      end
      A_CHK: begin
        e_nxt = free_r;
        if (free_r == NIL) begin
          st_nxt    = ST_FULL;
          state_nxt = S_RESP;
        end else if (d_r < 32'(WHEEL_SLOTS)) begin
          state_nxt = A_WH;
        end else if (hcnt_r == HCW'(HEAP_ENTRIES)) begin
          st_nxt    = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          state_nxt = A_HLINK;
        end
      end
      A_WH: begin
        free_nxt         = lk_q;
        lk_we            = 1'b1;
        lk_wd            = wh_q;
        wh_we            = 1'b1;
        wh_wd            = e_r;
        id_we            = 1'b1;
        act_nxt[e_r[TW-1:0]] = 1'b1;
        st_nxt           = ST_OK;
        state_nxt        = S_RESP;
      end
      A_HLINK: begin
        free_nxt         = lk_q;
        id_we            = 1'b1;
        act_nxt[e_r[TW-1:0]] = 1'b1;
        st_nxt           = ST_OK;
        hi_nxt           = '0;
        state_nxt        = A_SRD;
      end
      A_SRD: begin
        if (hi_r == hcnt_ext) begin
          // new time: hole at the end, sift it up
          hcnt_nxt  = hcnt_r + HCW'(1);
          lk_we     = 1'b1;
          lk_wd     = NIL;
          state_nxt = A_UPRD;
        end else begin
          state_nxt = A_SCMP;
        end
      end
      A_SCMP: begin
        alu_req.a = hk_q;
        alu_req.b = exp_r;
        if (alu_rsp.eq) begin
          lk_we     = 1'b1;
          lk_wd     = hh_q;
          hp_we     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          hi_nxt    = hi_r + CW'(1);
          state_nxt = A_SRD;
        end
      end
      A_UPRD: begin
        if (hi_r == '0) begin
          hp_we     = 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = A_UPCMP;
        end
      end
      A_UPCMP: begin
        alu_req.a = exp_r;
        alu_req.b = hk_q;
        hp_we     = 1'b1;
        if (alu_rsp.lt) begin
          hp_wkey   = hk_q;
          hp_whead  = hh_q;
          hi_nxt    = par;
          state_nxt = A_UPRD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      // ---- cancel
      C_START: begin
        if (id_r == 32'd0) begin
          st_nxt    = ST_INVALID;
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = '0;
          ph_nxt    = 1'b0;
          state_nxt = C_WRD;
        end
      end
      C_WRD: begin
        if (idx_r == IW'(WHEEL_SLOTS)) begin
          idx_nxt   = '0;
          ph_nxt    = 1'b1;
          state_nxt = C_HRD;
        end else begin
          state_nxt = C_WQ;
        end
      end
      C_WQ: begin
        e_nxt     = wh_q;
        state_nxt = C_WALK;
      end
      C_WALK: begin
        if (e_r == NIL) begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = ph_r ? C_HRD : C_WRD;
        end else begin
          state_nxt = C_ECMP;
        end
      end
      C_ECMP: begin
        if (id_q == id_r) begin
          act_nxt[e_r[TW-1:0]] = 1'b0;
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end else begin
          e_nxt     = lk_q;
          state_nxt = C_WALK;
        end
      end
      C_HRD: begin
        if (idx_r == IW'(hcnt_r)) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else begin
          state_nxt = C_HQ;
        end
      end
      C_HQ: begin
        e_nxt     = hh_q;
        state_nxt = C_WALK;
      end
      // ---- tick: wheel slot
      T_CALC: begin
        alu_req.a = now_r;
        alu_req.b = 64'd1;
        now_nxt   = alu_rsp.sum;
        state_nxt = T_WRD;
      end
      T_WRD: state_nxt = T_WQ;
      T_WQ: begin
        e_nxt     = wh_q;
        wh_we     = 1'b1;
        wh_wa     = now_r[SW-1:0];
        wh_wd     = NIL;
        cnt_nxt   = '0;
        state_nxt = T_PUSH;
      end
      T_PUSH: begin
        if (e_r == NIL) begin
          state_nxt = T_POP;
        end else begin
          stk_we    = 1'b1;
          cnt_nxt   = cnt_r + CNW'(1);
          state_nxt = T_LNK;
        end
      end
      T_LNK: begin
        e_nxt     = lk_q;
        state_nxt = T_PUSH;
      end
      T_POP: begin
        if (cnt_r == '0) begin
          state_nxt = T_HROOT;
        end else begin
          cnt_nxt   = cnt_r - CNW'(1);
          state_nxt = T_PE;
        end
      end
      T_PE: begin
        e_nxt     = stk_q;
        state_nxt = T_PRD;
      end
      T_PRD: state_nxt = T_PACT;
      T_PACT, T_WACT: begin
        // one result is held back so that the final one can carry last
        if (!(act_r[e_r[TW-1:0]] && pend_vld_r && !out_free)) begin
          if (act_r[e_r[TW-1:0]]) begin
            if (pend_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_kind_nxt = KIND_EXPIRY;
              out_st_nxt   = ST_OK;
              out_id_nxt   = pend_id_r;
              out_last_nxt = 1'b0;
            end
            pend_id_nxt  = id_q;
            pend_vld_nxt = 1'b1;
          end
          act_nxt[e_r[TW-1:0]] = 1'b0;
          lk_we    = 1'b1;
          lk_wd    = free_r;
          free_nxt = e_r;
          if (state_r == T_WACT) begin
            e_nxt     = lk_q;
            state_nxt = T_WALK;
          end else begin
            state_nxt = T_POP;
          end
        end
      end
      // ---- tick: heap roots
      T_HROOT: begin
        state_nxt = (hcnt_r == '0) ? T_FLUSH : T_HCMP;
      end
      T_HCMP: begin
        alu_req.a = now_r;
        alu_req.b = hk_q;
        if (alu_rsp.lt) begin
          state_nxt = T_FLUSH;
        end else begin
          e_nxt     = hh_q;
          hcnt_nxt  = hcnt_r - HCW'(1);
          state_nxt = T_PLAST;
        end
      end
      T_PLAST: state_nxt = T_PLQ;
      T_PLQ: begin
        lk_nxt    = hk_q;
        lh_nxt    = hh_q;
        hi_nxt    = '0;
        state_nxt = T_SDL;
      end
      T_SDL: begin
        if (lft < hcnt_ext) begin
          state_nxt = T_SDLQ;
        end else begin
          hp_we     = 1'b1;
          hp_wkey   = lk_r;
          hp_whead  = lh_r;
          state_nxt = T_WALK;
        end
      end
      T_SDLQ: begin
        alu_req.a = hk_q;
        alu_req.b = lk_r;
        if (alu_rsp.lt) begin
          mk_nxt   = hk_q;
          mh_nxt   = hh_q;
          m_nxt    = lft;
          msel_nxt = 1'b1;
        end else begin
          mk_nxt   = lk_r;
          mh_nxt   = lh_r;
          msel_nxt = 1'b0;
        end
        state_nxt = T_SDR;
      end
      T_SDR: begin
        state_nxt = (rgt < hcnt_ext) ? T_SDRQ : T_SDDEC;
      end
      T_SDRQ: begin
        alu_req.a = hk_q;
        alu_req.b = mk_r;
        if (alu_rsp.lt) begin
          mk_nxt   = hk_q;
          mh_nxt   = hh_q;
          m_nxt    = rgt;
          msel_nxt = 1'b1;
        end
        state_nxt = T_SDDEC;
      end
      T_SDDEC: begin
        hp_we = 1'b1;
        if (!msel_r) begin
          hp_wkey   = lk_r;
          hp_whead  = lh_r;
          state_nxt = T_WALK;
        end else begin
          hp_wkey   = mk_r;
          hp_whead  = mh_r;
          hi_nxt    = m_r;
          state_nxt = T_SDL;
        end
      end
      T_WALK: begin
        state_nxt = (e_r == NIL) ? T_HROOT : T_WACT;
      end
      T_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = KIND_EXPIRY;
          out_st_nxt   = ST_OK;
          out_id_nxt   = pend_id_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      now_r      <= '0;
      idc_r      <= 32'd1;
      free_r     <= '0;
      hcnt_r     <= '0;
      act_r      <= '0;
      idx_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      now_r      <= now_nxt;
      idc_r      <= idc_nxt;
      free_r     <= free_nxt;
      hcnt_r     <= hcnt_nxt;
      act_r      <= act_nxt;
      idx_r      <= idx_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    exp_r      <= exp_nxt;
    mk_r       <= mk_nxt;
    lk_r       <= lk_nxt;
    id_r       <= id_nxt;
    d_r        <= d_nxt;
    pend_id_r  <= pend_id_nxt;
    e_r        <= e_nxt;
    mh_r       <= mh_nxt;
    lh_r       <= lh_nxt;
    cnt_r      <= cnt_nxt;
    ph_r       <= ph_nxt;
    msel_r     <= msel_nxt;
    hi_r       <= hi_nxt;
    m_r        <= m_nxt;
    kind_r     <= kind_nxt;
    st_r       <= st_nxt;
    out_kind_r <= out_kind_nxt;
    out_st_r   <= out_st_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ hdl/timer_wheel_heap_scheduler.sv @@
// ---------------------------------------------------------------------------
// timer_wheel_heap_scheduler
// Timer service: slot wheel for short delays, min-heap of expiry times for
// long ones, one shared 64-bit add/compare unit under a sequencer.
// ---------------------------------------------------------------------------
// Usage: after reset the block initialises the wheel and the free list, with
// in_stall high. It then takes one item at a time and holds in_stall until that
// item is done and its last result, if any, has been loaded into the output
// register. An add goes into the wheel if its delay is below WHEEL_SLOTS; else
// the heap is searched node by node for an equal expiry time, and a new time is
// placed at the end of the heap and sifted up. A cancel scans the wheel slots,
// then the heap nodes, walking each list until it finds the id. A tick advances
// the time, frees and reports the entries of the due wheel slot, then pops each
// due heap root, sifts the last node down and frees the root's list. The shared
// unit, the single-read-port memories and the one-entry-per-step list walks pace
// this work; a stalled output adds its own waiting.
module timer_wheel_heap_scheduler #(
  parameter int WHEEL_SLOTS   = tws_pkg::WHEEL_SLOTS_DEF,
  parameter int HEAP_ENTRIES  = tws_pkg::HEAP_ENTRIES_DEF,
  parameter int TIMER_ENTRIES = tws_pkg::TIMER_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_delay_ticks,
  input  logic [31:0] in_cancel_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_timer_id,
  output logic        out_last
);
  import tws_pkg::*;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  tws_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  tws_ctrl #(
    .WHEEL_SLOTS   (WHEEL_SLOTS),
    .HEAP_ENTRIES  (HEAP_ENTRIES),
    .TIMER_ENTRIES (TIMER_ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_delay_ticks (in_delay_ticks),
    .in_cancel_id   (in_cancel_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_timer_id   (out_timer_id),
    .out_last       (out_last),
    .alu_req        (alu_req),
    .alu_rsp        (alu_rsp)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the timer scheduler: a table of directed transfers,
// then random adds, cancels, ticks and undefined actions, every result compared
// with a typed expectation or a behavioural model of wheel, entry pool and heap.
// ---------------------------------------------------------------------------
module tb;
  import tws_pkg::*;

  localparam int SLOTS = 256;
  localparam int HEAPN = 32;
  localparam int POOL  = 64;
  localparam int NIL   = POOL;
  localparam int LIMIT = 5000000;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] id;
    bit          last;
  } note_t;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] dly;
    logic [31:0] cid;
    bit          typed;   // expectation written into the table
    bit          silent;  // typed row that gives no result
    note_t       t;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_ADD;
  logic [31:0] in_delay_ticks = '0;
  logic [31:0] in_cancel_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [1:0] out_status;
  logic [31:0] out_timer_id;
  logic out_last;

  timer_wheel_heap_scheduler dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [63:0] now_t;
  logic [31:0] next_id;
  int          slot_head [SLOTS];
  logic [63:0] ent_exp [POOL];
  logic [31:0] ent_id [POOL];
  bit          ent_live [POOL];
  int          ent_next [POOL];
  logic [63:0] hkey [HEAPN];
  int          hlist [HEAPN];
  int          hcount;
  int          free_top;

  note_t step_q[$];
  note_t due_q[$];
  row_t  rows[$];
  logic [31:0] issued[$];

  int  mism = 0, checked = 0, n_add = 0, n_cancel = 0, n_tick = 0, n_full = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;

  task automatic model_reset();
    now_t = '0;
    next_id = 32'd1;
    foreach (slot_head[i]) slot_head[i] = NIL;
    foreach (ent_next[i]) begin
      ent_next[i] = i + 1;
      ent_live[i] = 1'b0;
    end
    hcount = 0;
    free_top = 0;
  endtask

  task automatic emit(input logic [1:0] k, input logic [1:0] s, input logic [31:0] id);
    note_t n;
    n.kind = k; n.status = s; n.id = id; n.last = 1'b0;
    step_q.push_back(n);
  endtask

  function automatic void hswap(input int a, input int b);
    logic [63:0] k;
    int h;
    k = hkey[a]; h = hlist[a];
    hkey[a] = hkey[b]; hlist[a] = hlist[b];
    hkey[b] = k; hlist[b] = h;
  endfunction

  task automatic free_ent(input int e);
    ent_live[e] = 1'b0;
    ent_next[e] = free_top;
    free_top = e;
  endtask

  task automatic expire_walk(input int e);
    while (e < POOL) begin
      int nx;
      nx = ent_next[e];
      if (ent_live[e] && step_q.size() < POOL) emit(KIND_EXPIRY, ST_OK, ent_id[e]);
      free_ent(e);
      e = nx;
    end
  endtask

  function automatic logic [1:0] timer_add(input logic [31:0] dly, input logic [31:0] id);
    logic [63:0] d, ex;
    int e, i, p, m;
    d = (dly == 0) ? 64'd1 : {32'd0, dly};
    ex = now_t + d;
    if (free_top >= POOL) return ST_FULL;
    e = free_top;
    if (d < SLOTS) begin
      free_top = ent_next[e];
      ent_next[e] = slot_head[ex % SLOTS];
      slot_head[ex % SLOTS] = e;
    end else begin
      if (hcount >= HEAPN) return ST_FULL;
      free_top = ent_next[e];
      m = -1;
      for (i = 0; i < hcount; i++) if (m < 0 && hkey[i] == ex) m = i;
      if (m >= 0) begin
        ent_next[e] = hlist[m];
        hlist[m] = e;
      end else begin
        i = hcount++;
        hkey[i] = ex; hlist[i] = e; ent_next[e] = NIL;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (hkey[i] >= hkey[p]) break;
          hswap(i, p);
          i = p;
        end
      end
    end
    ent_exp[e] = ex; ent_id[e] = id; ent_live[e] = 1'b1;
    return ST_OK;
  endfunction

  function automatic bit mark_dead(input int e, input logic [31:0] id);
    while (e < POOL) begin
      if (ent_id[e] == id) begin
        ent_live[e] = 1'b0;
        return 1'b1;
      end
      e = ent_next[e];
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] timer_cancel(input logic [31:0] id);
    if (id == 0) return ST_INVALID;
    for (int i = 0; i < SLOTS; i++) if (mark_dead(slot_head[i], id)) return ST_OK;
    for (int i = 0; i < hcount; i++) if (mark_dead(hlist[i], id)) return ST_OK;
    return ST_NOTFOUND;
  endfunction

  task automatic timer_tick();
    int tmp[$];
    int e, s, i, m, l, r;
    now_t = now_t + 1;
    s = now_t % SLOTS;
    e = slot_head[s];
    while (e < POOL && tmp.size() < POOL) begin
      tmp.push_back(e);
      e = ent_next[e];
    end
    slot_head[s] = NIL;
    while (tmp.size() > 0) begin
      e = tmp.pop_back();
      if (ent_live[e] && step_q.size() < POOL) emit(KIND_EXPIRY, ST_OK, ent_id[e]);
      free_ent(e);
    end
    while (hcount > 0 && hkey[0] <= now_t) begin
      e = hlist[0];
      hcount--;
      hkey[0] = hkey[hcount]; hlist[0] = hlist[hcount];
      i = 0;
      forever begin
        m = i; l = 2 * i + 1; r = 2 * i + 2;
        if (l < hcount && hkey[l] < hkey[m]) m = l;
        if (r < hcount && hkey[r] < hkey[m]) m = r;
        if (m == i) break;
        hswap(i, m);
        i = m;
      end
      expire_walk(e);
    end
  endtask

  // predicted results of one accepted transfer land in step_q
  task automatic timer_step(input logic [1:0] a, input logic [31:0] d, input logic [31:0] c);
    logic [31:0] id;
    step_q.delete();
    case (a)
      ACT_ADD: begin
        id = next_id;
        next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 1;
        emit(KIND_ADD, timer_add(d, id), id);
        issued.push_back(id);
        n_add++;
      end
      ACT_CANCEL: begin
        emit(KIND_CANCEL, timer_cancel(c), c);
        n_cancel++;
      end
      ACT_TICK: begin
        timer_tick();
        n_tick++;
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endtask

  task automatic send(input row_t rw);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= rw.act;
    in_delay_ticks <= rw.dly;
    in_cancel_id <= rw.cid;
    do @(posedge clk); while (in_stall);
    timer_step(rw.act, rw.dly, rw.cid);
    if (rw.typed) begin
      if (!rw.silent) due_q.push_back(rw.t);
    end else begin
      foreach (step_q[i]) due_q.push_back(step_q[i]);
    end
  endtask

  function automatic row_t mk(input logic [1:0] a, input logic [31:0] d, input logic [31:0] c);
    row_t rw;
    rw.act = a; rw.dly = d; rw.cid = c; rw.typed = 1'b0; rw.silent = 1'b0;
    rw.t = '{KIND_ADD, ST_OK, 32'd0, 1'b1};
    return rw;
  endfunction

  function automatic row_t mkt(input logic [1:0] a, input logic [31:0] d, input logic [31:0] c,
                               input logic [1:0] k, input logic [1:0] s, input logic [31:0] id);
    row_t rw;
    rw = mk(a, d, c);
    rw.typed = 1'b1;
    rw.t = '{k, s, id, 1'b1};
    return rw;
  endfunction

  function automatic row_t rand_row();
    int sel;
    logic [31:0] d, c;
    sel = $urandom_range(0, 99);
    d = '0; c = '0;
    case ($urandom_range(0, 9))
      0:       d = $urandom;
      1:       d = $urandom_range(254, 257);
      2, 3:    d = $urandom_range(256, 320);
      default: d = $urandom_range(0, 40);
    endcase
    case ($urandom_range(0, 9))
      0:       c = $urandom;
      1:       c = 32'd0;
      default: c = (issued.size() > 0) ?
                   issued[$urandom_range(issued.size() > 60 ? issued.size() - 60 : 0,
                                         issued.size() - 1)] : 32'd1;
    endcase
    if (sel < 45) return mk(ACT_ADD, d, c);
    if (sel < 63) return mk(ACT_CANCEL, d, c);
    if (sel < 97) return mk(ACT_TICK, d, c);
    return mk(2'd3, d, c);
  endfunction

  // output side idling
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected result kind=%0d status=%0d id=%h last=%0d",
                   out_kind, out_status, out_timer_id, out_last);
      end else begin
        note_t w;
        w = due_q.pop_front();
        checked++;
        if (out_status == ST_FULL) n_full++;
        if (out_kind !== w.kind || out_status !== w.status || out_timer_id !== w.id ||
            out_last !== w.last) begin
          mism++;
          if (mism <= 10)
            $display("mismatch: exp kind=%0d status=%0d id=%h last=%0d, got %0d %0d %h %0d",
                     w.kind, w.status, w.id, w.last,
                     out_kind, out_status, out_timer_id, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back(mkt(ACT_ADD, 32'd0, 32'd0, KIND_ADD, ST_OK, 32'd1));
    rows.push_back(mk(ACT_ADD, 32'd255, 32'hFFFF_FFFF));
    rows.push_back(mk(ACT_ADD, 32'd256, 32'd0));
    rows.push_back(mk(ACT_ADD, 32'hFFFF_FFFF, 32'd0));
    rows.push_back(mk(ACT_ADD, 32'd300, 32'd0));
    rows.push_back(mk(ACT_ADD, 32'd300, 32'd0));
    rows.push_back(mk(ACT_ADD, 32'd1, 32'd0));
    rows.push_back(mk(ACT_ADD, 32'd1, 32'd0));
    rows.push_back(mkt(ACT_CANCEL, 32'd0, 32'd0, KIND_CANCEL, ST_INVALID, 32'd0));
    rows.push_back(mkt(ACT_CANCEL, 32'd0, 32'hFFFF_FFFF, KIND_CANCEL, ST_NOTFOUND,
                       32'hFFFF_FFFF));
    rows.push_back(mk(ACT_CANCEL, 32'hFFFF_FFFF, 32'd7));
    rows.push_back(mk(ACT_CANCEL, 32'd0, 32'd7));
    rows.push_back(mk(ACT_CANCEL, 32'd0, 32'd6));
    begin
      row_t r3;
      r3 = mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      r3.typed = 1'b1; r3.silent = 1'b1;
      rows.push_back(r3);
    end
    rows.push_back(mk(ACT_TICK, 32'd0, 32'd0));
    rows.push_back(mk(ACT_TICK, 32'd0, 32'd0));
    rows.push_back(mk(ACT_CANCEL, 32'd0, 32'd1));
    for (int i = 0; i < 30; i++) rows.push_back(mk(ACT_ADD, 32'd256 + i, 32'd0));
    for (int i = 0; i < 6; i++) rows.push_back(mk(ACT_ADD, 32'd3, 32'd0));
    rows.push_back(mk(ACT_TICK, 32'd0, 32'd0));
    rows.push_back(mk(ACT_TICK, 32'd0, 32'd0));
    rows.push_back(mk(ACT_TICK, 32'd0, 32'd0));
    foreach (rows[i]) send(rows[i]);

    for (int n = 0; n < 500; n++) begin
      if (n == 250) begin
        in_valid <= 1'b0;
        while (due_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (n == 440) quiet = 1'b1;
      send(rand_row());
    end
    in_valid <= 1'b0;

    while (due_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (due_q.size() != 0) mism++;
    $display("covered %0d adds, %0d cancels, %0d ticks; %0d results checked, %0d store-full",
             n_add, n_cancel, n_tick, checked, n_full);
    if (mism == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d failures", mism);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
